>>> sv/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants and types for the page-organized monochrome framebuffer.
// ----------------------------------------------------------------------------
package mpfb_pkg;

	localparam int DEF_PANEL_WIDTH  = 128;
	localparam int DEF_PANEL_HEIGHT = 64;
	localparam int PAGE_ROWS        = 8;
	localparam int BYTE_W           = 8;

	localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

	typedef enum logic [2:0] {
		MODE_FILL  = 3'd0,
		MODE_PIXEL = 3'd1,
		MODE_HLINE = 3'd2,
		MODE_VLINE = 3'd3,
		MODE_READ  = 3'd4
	} mode_t;

endpackage

>>> sv/mpfb_ram.sv
// ----------------------------------------------------------------------------
// mpfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/mono_page_framebuffer_draw.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// Monochrome framebuffer, eight vertical pixels per byte, page-major layout.
// ----------------------------------------------------------------------------
// Drawing goes through the frame RAM's single write port: fill writes every byte, pixel does
//   one read-modify-write, horizontal line a pipelined read-modify-write of its page,
//   vertical line one byte per page; off-panel and other modes write nothing.
// A read result appears with valid once the RAM read is registered and ST_READ has
// captured it; a read off the panel raises valid the next cycle with byte_value zero.
// After reset the RAM is cleared to zero, all PANEL_WIDTH*pages bytes, one byte a cycle,
// with busy high. The receiver cannot stall.
module mono_page_framebuffer_draw #(
	parameter int PANEL_WIDTH  = mpfb_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = mpfb_pkg::DEF_PANEL_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [7:0] column,
	input  logic [7:0] row,
	input  logic       ink,
	output logic       valid,
	output logic [7:0] byte_value
);

	localparam int PAGES = (PANEL_HEIGHT + mpfb_pkg::PAGE_ROWS - 1) / mpfb_pkg::PAGE_ROWS;
	localparam int DEPTH = PANEL_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FILL  = 6'b000010,
		ST_RMW   = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_VLINE = 6'b010000,
		ST_READ  = 6'b100000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   remain_q;
	logic [7:0]      fill_q;
	logic [7:0]      mask_q;
	logic            on_q;
	logic            rmw_s1;
	logic [AW-1:0]   addr_s1;
	logic            valid_q;
	logic [7:0]      byte_q;

	logic            accept;
	logic            col_ok;
	logic            row_ok;
	logic [AW-1:0]   page_base;
	logic [AW-1:0]   pix_addr;
	logic [7:0]      pix_mask;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign valid      = valid_q;
	assign byte_value = byte_q;

	assign col_ok    = ({1'b0, column} < 9'(PANEL_WIDTH));
	assign row_ok    = ({1'b0, row} < 9'(PANEL_HEIGHT));
	assign page_base = AW'(32'(row[7:3]) * 32'(PANEL_WIDTH));
	assign pix_addr  = page_base + AW'(column);
	assign pix_mask  = 8'b1 << row[2:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = fill_q;
		if (state_q == ST_FILL || state_q == ST_VLINE) begin
			ram_we = 1'b1;
		end else if (rmw_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = on_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		if (state_q == ST_RMW) begin
			ram_re = 1'b1;
		end else if (accept && mode == mpfb_pkg::MODE_READ) begin
			ram_re    = 1'b1;
			ram_raddr = pix_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			addr_q   <= '0;
			remain_q <= AW'(DEPTH - 1);
			fill_q   <= mpfb_pkg::BYTE_ZEROS;
			rmw_s1   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			rmw_s1  <= (state_q == ST_RMW);
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode)
							mpfb_pkg::MODE_FILL: begin
								fill_q   <= ink ? mpfb_pkg::BYTE_ONES
									: mpfb_pkg::BYTE_ZEROS;
								addr_q   <= '0;
								remain_q <= AW'(DEPTH - 1);
								state_q  <= ST_FILL;
							end
							mpfb_pkg::MODE_PIXEL: begin
								if (col_ok && row_ok) begin
									addr_q   <= pix_addr;
									remain_q <= '0;
									state_q  <= ST_RMW;
								end
							end
							mpfb_pkg::MODE_HLINE: begin
								if (row_ok) begin
									addr_q   <= page_base;
									remain_q <= AW'(PANEL_WIDTH - 1);
									state_q  <= ST_RMW;
								end
							end
							mpfb_pkg::MODE_VLINE: begin
								if (col_ok) begin
									fill_q   <= ink ? mpfb_pkg::BYTE_ONES
										: mpfb_pkg::BYTE_ZEROS;
									addr_q   <= AW'(column);
									remain_q <= AW'(PAGES - 1);
									state_q  <= ST_VLINE;
								end
							end
							mpfb_pkg::MODE_READ: begin
								if (col_ok && row_ok) begin
									state_q <= ST_READ;
								end else begin
									valid_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					if (remain_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						remain_q <= remain_q - 1'b1;
						addr_q   <= addr_q + 1'b1;
					end
				end
				ST_RMW: begin
					if (remain_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						remain_q <= remain_q - 1'b1;
						addr_q   <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_VLINE: begin
					if (remain_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						remain_q <= remain_q - 1'b1;
						addr_q   <= addr_q + AW'(PANEL_WIDTH);
					end
				end
				ST_READ: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (accept && (mode == mpfb_pkg::MODE_PIXEL || mode == mpfb_pkg::MODE_HLINE)) begin
			mask_q <= pix_mask;
			on_q   <= ink;
		end
		if (state_q == ST_READ) begin
			byte_q <= ram_rdata;
		end else if (state_q == ST_IDLE) begin
			byte_q <= mpfb_pkg::BYTE_ZEROS;
		end
	end

	mpfb_ram #(
		.WIDTH(mpfb_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTH
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ($past(state_q) == ST_READ) || ($past(accept)
			&& ($past(mode) == mpfb_pkg::MODE_READ)))
		else $error("result without a read beat");

	a_wr_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(rmw_s1 && (state_q == ST_FILL || state_q == ST_VLINE)))
		else $error("write-back collides with sweep write");

	a_fill_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == mpfb_pkg::MODE_FILL) |=> (state_q == ST_FILL))
		else $error("fill beat did not start a sweep");

	a_rmw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> (remain_q <= AW'(PANEL_WIDTH - 1)))
		else $error("line count out of range");
`endif

endmodule

>>> dv/mono_page_framebuffer_draw_tb.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_tb
// Drives drawing and read commands into the page-organized framebuffer and
// checks every read-back byte against a local image of the frame, kept up to
// date beat by beat as commands are accepted.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW           = mpfb_pkg::DEF_PANEL_WIDTH;
	localparam int PH           = mpfb_pkg::DEF_PANEL_HEIGHT;
	localparam int PAGES        = (PH + mpfb_pkg::PAGE_ROWS - 1) / mpfb_pkg::PAGE_ROWS;
	localparam int STORE        = PW * PAGES;
	localparam int MODE_SPACE   = 2 ** $bits(mpfb_pkg::mode_t);
	localparam int RANDOM_BEATS = 555;
	localparam int MAX_SHOWN    = 10;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] mode;
	logic [7:0] column;
	logic [7:0] row;
	logic       ink;
	logic       valid;
	logic [7:0] byte_value;

	logic [mpfb_pkg::BYTE_W-1:0] frame_image [STORE];
	logic [mpfb_pkg::BYTE_W-1:0] read_bytes_q [$];
	int                          mismatches = 0;
	logic                        got_valid;
	logic [7:0]                  got_byte;

	mono_page_framebuffer_draw #(
		.PANEL_WIDTH (PW),
		.PANEL_HEIGHT(PH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.column    (column),
		.row       (row),
		.ink       (ink),
		.valid     (valid),
		.byte_value(byte_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("mono_page_framebuffer_draw: mismatch");
		$finish;
	end

	function automatic void draw_frame(input logic [2:0] op, input logic [7:0] x,
			input logic [7:0] y, input logic on);
		int                          pg;
		logic [mpfb_pkg::BYTE_W-1:0] mask;
		pg   = y / mpfb_pkg::PAGE_ROWS;
		mask = mpfb_pkg::BYTE_W'(1) << (y % mpfb_pkg::PAGE_ROWS);
		case (op)
			mpfb_pkg::MODE_FILL: begin
				foreach (frame_image[i])
					frame_image[i] = on ? mpfb_pkg::BYTE_ONES : mpfb_pkg::BYTE_ZEROS;
			end
			mpfb_pkg::MODE_PIXEL: begin
				if (x < PW && y < PH)
					frame_image[x + pg * PW] = on ? (frame_image[x + pg * PW] | mask)
						: (frame_image[x + pg * PW] & ~mask);
			end
			mpfb_pkg::MODE_HLINE: begin
				if (y < PH)
					for (int k = 0; k < PW; k++)
						frame_image[k + pg * PW] = on ? (frame_image[k + pg * PW] | mask)
							: (frame_image[k + pg * PW] & ~mask);
			end
			mpfb_pkg::MODE_VLINE: begin
				if (x < PW)
					for (int k = 0; k < PAGES; k++)
						frame_image[x + k * PW] = on ? mpfb_pkg::BYTE_ONES
							: mpfb_pkg::BYTE_ZEROS;
			end
			mpfb_pkg::MODE_READ: begin
				read_bytes_q.push_back((x < PW && y < PH) ? frame_image[x + pg * PW]
					: mpfb_pkg::BYTE_ZEROS);
			end
			default: ;
		endcase
	endfunction

	task automatic send_op(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
			input logic on);
		@(negedge clk);
		start  <= 1'b1;
		mode   <= op;
		column <= x;
		row    <= y;
		ink    <= on;
		do @(posedge clk); while (busy);
		draw_frame(op, x, y, on);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (read_bytes_q.size() != 0) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [7:0] exp_byte,
			input logic [7:0] act_byte);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s expected %02h got %02h", $realtime, what, exp_byte, act_byte);
	endtask

	always @(posedge clk) begin
		got_valid <= valid;
		got_byte  <= byte_value;
	end

	always @(negedge clk) begin
		logic [7:0] exp_byte;
		if (got_valid === 1'b1) begin
			if (read_bytes_q.size() == 0) begin
				note_mismatch("unexpected read beat:", 8'h00, got_byte);
			end else begin
				exp_byte = read_bytes_q.pop_front();
				if (got_byte !== exp_byte)
					note_mismatch("byte_value:", exp_byte, got_byte);
			end
		end
	end

	task automatic test_after_reset();
		send_op(mpfb_pkg::MODE_READ, 8'd0, 8'd0, 1'b0);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'(PH - 1), 1'b1);
	endtask

	task automatic test_fill();
		send_op(mpfb_pkg::MODE_FILL, 8'd0, 8'd0, 1'b1);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'(PH - 1), 1'b0);
		send_op(mpfb_pkg::MODE_FILL, 8'd255, 8'd255, 1'b0);
	endtask

	task automatic test_pixel();
		send_op(mpfb_pkg::MODE_PIXEL, 8'd0, 8'd0, 1'b1);
		send_op(mpfb_pkg::MODE_PIXEL, 8'(PW - 1), 8'(PH - 1), 1'b1);
		send_op(mpfb_pkg::MODE_PIXEL, 8'(PW), 8'd0, 1'b1);
		send_op(mpfb_pkg::MODE_PIXEL, 8'd0, 8'(PH), 1'b1);
		send_op(mpfb_pkg::MODE_READ, 8'd0, 8'd0, 1'b0);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'(PH - 1), 1'b0);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'd0, 1'b0);
	endtask

	task automatic test_hline();
		send_op(mpfb_pkg::MODE_HLINE, 8'd0, 8'(PH - 1), 1'b1);
		send_op(mpfb_pkg::MODE_HLINE, 8'd0, 8'd200, 1'b1);
		send_op(mpfb_pkg::MODE_READ, 8'(PW / 2), 8'(PH - 1), 1'b0);
		send_op(mpfb_pkg::MODE_HLINE, 8'd255, 8'(PH - 1), 1'b0);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'(PH - 1), 1'b0);
	endtask

	task automatic test_vline();
		send_op(mpfb_pkg::MODE_VLINE, 8'(PW - 1), 8'd255, 1'b1);
		send_op(mpfb_pkg::MODE_VLINE, 8'd200, 8'd0, 1'b1);
		send_op(mpfb_pkg::MODE_READ, 8'(PW - 1), 8'd0, 1'b0);
	endtask

	task automatic test_read_off_panel();
		send_op(mpfb_pkg::MODE_READ, 8'd255, 8'd255, 1'b1);
		send_op(mpfb_pkg::MODE_READ, 8'(PW), 8'd0, 1'b0);
	endtask

	task automatic test_unused_modes();
		for (int m = int'(mpfb_pkg::MODE_READ) + 1; m < MODE_SPACE; m++)
			send_op(3'(m), 8'(PW - 1), 8'd0, 1'b1);
	endtask

	task automatic pick_xy(output logic [7:0] x, output logic [7:0] y);
		x = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(PW - 1));
		y = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(PH - 1));
	endtask

	task automatic test_random();
		int         beats;
		int         burst;
		int         pick;
		logic [7:0] x;
		logic [7:0] y;
		logic       on;
		logic [2:0] op;
		logic       paused;
		beats  = 0;
		paused = 1'b0;
		while (beats < RANDOM_BEATS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				pick = $urandom_range(99);
				pick_xy(x, y);
				on = 1'($urandom_range(1));
				if (pick < 3)
					op = mpfb_pkg::MODE_FILL;
				else if (pick < 40)
					op = mpfb_pkg::MODE_PIXEL;
				else if (pick < 48)
					op = mpfb_pkg::MODE_HLINE;
				else if (pick < 55)
					op = mpfb_pkg::MODE_VLINE;
				else if (pick < 95)
					op = mpfb_pkg::MODE_READ;
				else
					op = 3'($urandom_range(int'(mpfb_pkg::MODE_READ) + 1, MODE_SPACE - 1));
				send_op(op, x, y, on);
				beats++;
				if (op == mpfb_pkg::MODE_PIXEL && $urandom_range(2) == 0) begin
					send_op(mpfb_pkg::MODE_READ, x, y, 1'($urandom_range(1)));
					beats++;
				end
			end
			if (!paused && beats >= RANDOM_BEATS / 2) begin
				wait_drained();
				paused = 1'b1;
			end else if ($urandom_range(3) != 0) begin
				hold_off($urandom_range(10));
			end
		end
	endtask

	initial begin
		foreach (frame_image[i])
			frame_image[i] = mpfb_pkg::BYTE_ZEROS;
		arst_n = 1'b0;
		start  = 1'b0;
		mode   = mpfb_pkg::MODE_FILL;
		column = 8'd0;
		row    = 8'd0;
		ink    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_fill();
		test_pixel();
		test_hline();
		test_vline();
		test_read_off_panel();
		test_unused_modes();
		wait_drained();
		test_random();

		wait_drained();
		repeat (STORE + 16) @(posedge clk);
		if (mismatches == 0 && read_bytes_q.size() == 0) begin
			$display("mono_page_framebuffer_draw: match");
		end else begin
			$display("mono_page_framebuffer_draw: mismatch");
		end
		$finish;
	end

endmodule

>>> files.f
sv/mpfb_pkg.sv
sv/mpfb_ram.sv
sv/mono_page_framebuffer_draw.sv
dv/mono_page_framebuffer_draw_tb.sv
